@@ hw/rtl/lz_bitstream_decompressor_unit_assert.svh @@
// Assertion macros shared by the LZ bit-stream decompressor modules.
`ifndef LZ_BITSTREAM_DECOMPRESSOR_UNIT_ASSERT_SVH
`define LZ_BITSTREAM_DECOMPRESSOR_UNIT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LZBD_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("lzbd same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define LZBD_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("lzbd next-cycle check failed");

`endif

@@ hw/rtl/lzbd_pkg.sv @@
// Shared constants and types of the LZ bit-stream decompressor.
`timescale 1ns / 1ps

package lzbd_pkg;

   localparam int WINDOW_DEPTH_DEF    = 16384;
   localparam int MAX_OFFSET_BITS_DEF = 14;
   localparam int LANES_DEF           = 8;
   localparam int OUT_LANES           = 8;
   localparam int BYTE_W              = 8;
   localparam int SIZE_W              = 32;
   localparam int COUNT_W             = 4;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              done;
      logic              err;
   } lzbd_push_type;

endpackage

@@ hw/rtl/lz_bitstream_decompressor_unit.sv @@
// Top level of the LZ bit-stream decompressor.
`timescale 1ns / 1ps
// Usage:
// The request channel (req_valid, req_stall, req_in_bit) takes the compressed
// stream one bit per request, most significant bit of each byte first. The
// response channel (rsp_valid, rsp_stall, rsp_*) returns decoded bytes in groups
// of up to Lanes bytes, with rsp_last_of_run on the final group of a token.
// Write csr_write_data through csr_write_enable to set the output size while idle.
// A literal response is registered in the cycle after its eighth bit. A match is
// copied through the window memory at one byte per cycle while the response is
// not stalled, and the request side stalls while the copy runs. The registered
// read of the window memory sets this copy rate; distance one is served from a
// bypass. Once the output size is reached further bits are accepted and dropped.
// Reset is synchronous and active high; the window needs no clearing pass, since
// a copy whose offset is zero or exceeds the bytes written yields zero bytes. A
// stalled response holds its register and also stalls the copy and the request
// side, without losing bytes.

module lz_bitstream_decompressor_unit #(
   parameter int WindowDepth   = lzbd_pkg::WINDOW_DEPTH_DEF,
   parameter int MaxOffsetBits = lzbd_pkg::MAX_OFFSET_BITS_DEF,
   parameter int Lanes         = lzbd_pkg::LANES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_in_bit,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lzbd_pkg::BYTE_W-1:0]   rsp_byte_0,
   output logic [lzbd_pkg::BYTE_W-1:0]   rsp_byte_1,
   output logic [lzbd_pkg::BYTE_W-1:0]   rsp_byte_2,
   output logic [lzbd_pkg::BYTE_W-1:0]   rsp_byte_3,
   output logic [lzbd_pkg::BYTE_W-1:0]   rsp_byte_4,
   output logic [lzbd_pkg::BYTE_W-1:0]   rsp_byte_5,
   output logic [lzbd_pkg::BYTE_W-1:0]   rsp_byte_6,
   output logic [lzbd_pkg::BYTE_W-1:0]   rsp_byte_7,
   output logic [lzbd_pkg::COUNT_W-1:0]  rsp_byte_count,
   output logic                          rsp_last_of_run,
   output logic                          rsp_stream_done,
   output logic                          rsp_bad_offset,
   input  logic                          csr_write_enable,
   input  logic [lzbd_pkg::SIZE_W-1:0]   csr_write_data
);
   import lzbd_pkg::*;

   localparam int AW = $clog2(WindowDepth);

   lzbd_push_type     push;
   logic              pack_ready;
   logic              ram_wr_en, ram_rd_en;
   logic [AW-1:0]     ram_wr_addr, ram_rd_addr;
   logic [BYTE_W-1:0] ram_wr_data, ram_rd_data;
   logic [BYTE_W-1:0] rsp_bytes [OUT_LANES];

   lzbd_window_ram #(
      .Depth(WindowDepth)
   ) u_window (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   lzbd_decoder #(
      .WindowDepth  (WindowDepth),
      .MaxOffsetBits(MaxOffsetBits)
   ) u_decoder (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_bit      (req_in_bit),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .pack_ready      (pack_ready),
      .push            (push),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_en       (ram_rd_en),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data)
   );

   lzbd_packer #(
      .Lanes(Lanes)
   ) u_packer (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .pack_ready     (pack_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_bytes      (rsp_bytes),
      .rsp_byte_count (rsp_byte_count),
      .rsp_last_of_run(rsp_last_of_run),
      .rsp_stream_done(rsp_stream_done),
      .rsp_bad_offset (rsp_bad_offset)
   );

   assign rsp_byte_0 = rsp_bytes[0];
   assign rsp_byte_1 = rsp_bytes[1];
   assign rsp_byte_2 = rsp_bytes[2];
   assign rsp_byte_3 = rsp_bytes[3];
   assign rsp_byte_4 = rsp_bytes[4];
   assign rsp_byte_5 = rsp_bytes[5];
   assign rsp_byte_6 = rsp_bytes[6];
   assign rsp_byte_7 = rsp_bytes[7];

endmodule

@@ hw/rtl/lzbd_window_ram.sv @@
// Single-port-write, single-port-read history window with registered read data.
`timescale 1ns / 1ps

module lzbd_window_ram #(
   parameter int Depth = lzbd_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(Depth)-1:0]      wr_addr,
   input  logic [lzbd_pkg::BYTE_W-1:0]   wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(Depth)-1:0]      rd_addr,
   output logic [lzbd_pkg::BYTE_W-1:0]   rd_data
);
   import lzbd_pkg::*;

   logic [BYTE_W-1:0] mem [Depth];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/lzbd_decoder.sv @@
// Token parser and match copy sequencer of the LZ bit-stream decompressor.
`timescale 1ns / 1ps

module lzbd_decoder #(
   parameter int WindowDepth   = lzbd_pkg::WINDOW_DEPTH_DEF,
   parameter int MaxOffsetBits = lzbd_pkg::MAX_OFFSET_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_in_bit,
   input  logic                               csr_write_enable,
   input  logic [lzbd_pkg::SIZE_W-1:0]        csr_write_data,
   input  logic                               pack_ready,
   output lzbd_pkg::lzbd_push_type            push,
   output logic                               ram_wr_en,
   output logic [$clog2(WindowDepth)-1:0]     ram_wr_addr,
   output logic [lzbd_pkg::BYTE_W-1:0]        ram_wr_data,
   output logic                               ram_rd_en,
   output logic [$clog2(WindowDepth)-1:0]     ram_rd_addr,
   input  logic [lzbd_pkg::BYTE_W-1:0]        ram_rd_data
);
   import lzbd_pkg::*;
   `include "lz_bitstream_decompressor_unit_assert.svh"

   localparam int AW       = $clog2(WindowDepth);
   localparam int BW       = $clog2(MaxOffsetBits + 1);
   localparam int OffLimit = 1 << MaxOffsetBits;

   typedef enum logic [2:0] {
      PH_FLAG,
      PH_LIT,
      PH_OFF,
      PH_UNARY,
      PH_LEN8
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [BW-1:0]        bits_ff, bits_in;
   logic [MaxOffsetBits-1:0] off_ff, off_in;
   logic [BYTE_W-1:0]    len_ff, len_in;
   logic [2:0]           unary_ff, unary_in;
   logic                 err_ff, err_in;
   logic [SIZE_W-1:0]    pos_ff, pos_in;
   logic [SIZE_W-1:0]    size_ff, size_in;
   logic [BYTE_W-1:0]    copy_left_ff, copy_left_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic [AW-1:0]        src_ff, src_in;
   logic                 src_ok_ff, src_ok_in;
   logic                 fwd_ff, fwd_in;
   logic [BYTE_W-1:0]    last_byte_ff, last_byte_in;

   logic                 accept, take, copy_busy, lit_done, fin;
   logic                 issue, resolve, off_gt;
   logic [BYTE_W-1:0]    fin_len, copy_n, lit_byte, copy_byte, wr_byte;
   logic [SIZE_W-1:0]    pos_inc, remain, src_diff;
   logic [15:0]          pos_low;
   logic [BW-1:0]        off_width;

   function automatic logic [4:0] bit_len16(input logic [15:0] v);
      logic [4:0] n;
      n = '0;
      for (int i = 0; i < 16; i++) begin
         if (v[i]) begin
            n = 5'(i + 1);
         end
      end
      return n;
   endfunction

   always_comb begin
      copy_busy = (copy_left_ff != '0) || rd_pend_ff;
      req_stall = copy_busy || !pack_ready;
      accept    = req_valid && !req_stall;
      take      = accept && (pos_ff < size_ff);
      pos_inc   = pos_ff + 32'd1;

      lit_byte  = {len_ff[BYTE_W-2:0], req_in_bit};
      lit_done  = take && (phase_ff == PH_LIT) && (bits_ff == BW'(1));
      fin       = take && (((phase_ff == PH_UNARY) && req_in_bit) ||
                           ((phase_ff == PH_LEN8) && (bits_ff == BW'(1))));
      fin_len   = (phase_ff == PH_UNARY) ? {5'd0, unary_ff} : lit_byte;
      remain    = size_ff - pos_ff;
      copy_n    = (32'(fin_len) < remain) ? fin_len : remain[BYTE_W-1:0];
      off_gt    = 32'(off_ff) > pos_ff;
      src_diff  = pos_ff - 32'(off_ff);

      pos_low   = pos_ff[15:0];
      off_width = (17'(pos_low) < 17'(OffLimit)) ? BW'(bit_len16(pos_low))
                                                  : BW'(MaxOffsetBits);

      issue     = (copy_left_ff != '0) && pack_ready;
      resolve   = rd_pend_ff && pack_ready;
      copy_byte = !src_ok_ff ? '0 : (fwd_ff ? last_byte_ff : ram_rd_data);
      wr_byte   = lit_done ? lit_byte : copy_byte;

      ram_wr_en   = lit_done || resolve;
      ram_wr_addr = pos_ff[AW-1:0];
      ram_wr_data = wr_byte;
      ram_rd_en   = issue;
      ram_rd_addr = src_ff;

      push.valid = ram_wr_en;
      push.data  = wr_byte;
      push.last  = lit_done || (copy_left_ff == '0);
      push.done  = pos_inc >= size_ff;
      push.err   = err_ff;
   end

   always_comb begin
      phase_in     = phase_ff;
      bits_in      = bits_ff;
      off_in       = off_ff;
      len_in       = len_ff;
      unary_in     = unary_ff;
      err_in       = err_ff;
      pos_in       = pos_ff;
      size_in      = size_ff;
      copy_left_in = copy_left_ff;
      rd_pend_in   = rd_pend_ff;
      src_in       = src_ff;
      src_ok_in    = src_ok_ff;
      fwd_in       = fwd_ff;
      last_byte_in = last_byte_ff;

      if (csr_write_enable) begin
         size_in = csr_write_data;
      end

      if (take) begin
         unique case (phase_ff)
            PH_FLAG: begin
               if (!req_in_bit) begin
                  phase_in = PH_LIT;
                  bits_in  = BW'(BYTE_W);
                  len_in   = '0;
               end else begin
                  off_in   = '0;
                  unary_in = 3'd2;
                  bits_in  = off_width;
                  phase_in = (off_width == '0) ? PH_UNARY : PH_OFF;
               end
            end
            PH_LIT: begin
               len_in  = lit_byte;
               bits_in = bits_ff - BW'(1);
               if (bits_ff == BW'(1)) begin
                  phase_in = PH_FLAG;
               end
            end
            PH_OFF: begin
               off_in  = {off_ff[MaxOffsetBits-2:0], req_in_bit};
               bits_in = bits_ff - BW'(1);
               if (bits_ff == BW'(1)) begin
                  phase_in = PH_UNARY;
               end
            end
            PH_UNARY: begin
               if (!req_in_bit) begin
                  unary_in = unary_ff + 3'd1;
                  if (unary_ff == 3'd7) begin
                     phase_in = PH_LEN8;
                     bits_in  = BW'(BYTE_W);
                     len_in   = '0;
                  end
               end
            end
            PH_LEN8: begin
               len_in  = lit_byte;
               bits_in = bits_ff - BW'(1);
            end
            default: begin
               phase_in = PH_FLAG;
            end
         endcase
      end

      if (fin) begin
         phase_in     = PH_FLAG;
         unary_in     = 3'd2;
         err_in       = err_ff || off_gt;
         copy_left_in = copy_n;
         src_in       = src_diff[AW-1:0];
         src_ok_in    = (off_ff != '0) && !off_gt;
         fwd_in       = off_ff == MaxOffsetBits'(1);
      end

      if (pack_ready) begin
         rd_pend_in = issue;
         if (issue) begin
            copy_left_in = copy_left_ff - BYTE_W'(1);
            src_in       = src_ff + AW'(1);
         end
      end

      if (ram_wr_en) begin
         pos_in       = pos_inc;
         last_byte_in = wr_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FLAG;
         bits_ff      <= '0;
         off_ff       <= '0;
         len_ff       <= '0;
         unary_ff     <= 3'd2;
         err_ff       <= 1'b0;
         pos_ff       <= '0;
         size_ff      <= '0;
         copy_left_ff <= '0;
         rd_pend_ff   <= 1'b0;
         src_ok_ff    <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         bits_ff      <= bits_in;
         off_ff       <= off_in;
         len_ff       <= len_in;
         unary_ff     <= unary_in;
         err_ff       <= err_in;
         pos_ff       <= pos_in;
         size_ff      <= size_in;
         copy_left_ff <= copy_left_in;
         rd_pend_ff   <= rd_pend_in;
         src_ok_ff    <= src_ok_in;
         fwd_ff       <= fwd_in;
      end
      src_ff       <= src_in;
      last_byte_ff <= last_byte_in;
   end

   `LZBD_ASSERT_IMPLY(a_no_req_during_copy, clock, reset, copy_busy, !accept)
   `LZBD_ASSERT_NEXT(a_pos_step, clock, reset, push.valid, pos_ff == $past(pos_ff) + 32'd1)
   `LZBD_ASSERT_NEXT(a_err_sticky, clock, reset, err_ff, err_ff)

endmodule

@@ hw/rtl/lzbd_packer.sv @@
// Gathers decoded bytes into lane groups and holds the outgoing response register.
`timescale 1ns / 1ps

module lzbd_packer #(
   parameter int Lanes = lzbd_pkg::LANES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  lzbd_pkg::lzbd_push_type            push,
   output logic                               pack_ready,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [lzbd_pkg::BYTE_W-1:0]        rsp_bytes [lzbd_pkg::OUT_LANES],
   output logic [lzbd_pkg::COUNT_W-1:0]       rsp_byte_count,
   output logic                               rsp_last_of_run,
   output logic                               rsp_stream_done,
   output logic                               rsp_bad_offset
);
   import lzbd_pkg::*;
   `include "lz_bitstream_decompressor_unit_assert.svh"

   localparam int LW = (Lanes > 1) ? $clog2(Lanes) : 1;

   logic [BYTE_W-1:0]  acc_ff [Lanes];
   logic [BYTE_W-1:0]  acc_in [Lanes];
   logic [LW-1:0]      count_ff, count_in;
   logic               valid_ff, valid_in;
   logic [BYTE_W-1:0]  bytes_ff [OUT_LANES];
   logic [BYTE_W-1:0]  bytes_in [OUT_LANES];
   logic [COUNT_W-1:0] count_out_ff, count_out_in;
   logic               last_ff, last_in;
   logic               done_ff, done_in;
   logic               err_ff, err_in;
   logic               emit;
   logic [BYTE_W-1:0]  wide_acc [OUT_LANES];

   always_comb begin
      pack_ready = !valid_ff || !rsp_stall;
      emit       = push.valid && (push.last || (count_ff == LW'(Lanes - 1)));

      for (int i = 0; i < OUT_LANES; i++) begin
         wide_acc[i] = '0;
      end
      for (int i = 0; i < Lanes; i++) begin
         wide_acc[i] = acc_ff[i];
      end

      acc_in       = acc_ff;
      count_in     = count_ff;
      valid_in     = valid_ff && rsp_stall;
      bytes_in     = bytes_ff;
      count_out_in = count_out_ff;
      last_in      = last_ff;
      done_in      = done_ff;
      err_in       = err_ff;

      if (push.valid) begin
         if (emit) begin
            for (int i = 0; i < OUT_LANES; i++) begin
               if ((i < Lanes) && (LW'(i) == count_ff)) begin
                  bytes_in[i] = push.data;
               end else begin
                  bytes_in[i] = wide_acc[i];
               end
            end
            for (int i = 0; i < Lanes; i++) begin
               acc_in[i] = '0;
            end
            count_in     = '0;
            valid_in     = 1'b1;
            count_out_in = COUNT_W'(count_ff) + COUNT_W'(1);
            last_in      = push.last;
            done_in      = push.done;
            err_in       = push.err;
         end else begin
            acc_in[count_ff] = push.data;
            count_in         = count_ff + LW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Lanes; i++) begin
            acc_ff[i] <= '0;
         end
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      bytes_ff     <= bytes_in;
      count_out_ff <= count_out_in;
      last_ff      <= last_in;
      done_ff      <= done_in;
      err_ff       <= err_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_bytes       = bytes_ff;
   assign rsp_byte_count  = count_out_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_stream_done = done_ff;
   assign rsp_bad_offset  = err_ff;

   `LZBD_ASSERT_IMPLY(a_push_when_ready, clock, reset, push.valid, pack_ready)
   `LZBD_ASSERT_IMPLY(a_count_range, clock, reset, valid_ff,
      (count_out_ff != '0) && (count_out_ff <= COUNT_W'(Lanes)))
   `LZBD_ASSERT_NEXT(a_run_end_flush, clock, reset, push.valid && push.last,
      (count_ff == '0) && valid_ff && last_ff)

endmodule
